[hdl/mcc_pkg.sv]
// ----------------------------------------------------------------------------
// mcc_pkg
// Types, field widths, state codes, register indexes and reset values shared
// by the charge controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

	localparam int CODE_W     = 11;
	localparam int SAMPLE_W   = 13;
	localparam int SUM_W      = 16;
	localparam int TOTAL_W    = 17;
	localparam int POWER_W    = 29;
	localparam int OUT_PWR_W  = 28;
	localparam int DUTY_W     = 8;
	localparam int STATE_W    = 2;
	localparam int RETRY_W    = 5;
	localparam int TOL_W      = 8;
	localparam int LIMIT_W    = 15;
	localparam int TRIES_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [STATE_W-1:0] MODE_INITIAL     = 2'd0;
	localparam logic [STATE_W-1:0] MODE_TRACKING    = 2'd1;
	localparam logic [STATE_W-1:0] MODE_OVERCURRENT = 2'd2;
	localparam logic [STATE_W-1:0] MODE_STOPPED     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VOLTAGE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_TOLERANCE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATTERY_VOLTAGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DUTY        = 3'd5;

	localparam logic [CODE_W-1:0]  RST_TARGET_VOLTAGE      = 11'd537;
	localparam logic [TOL_W-1:0]   RST_VOLTAGE_TOLERANCE   = 8'd4;
	localparam logic [CODE_W-1:0]  RST_MIN_BATTERY_VOLTAGE = 11'd21;
	localparam logic [LIMIT_W-1:0] RST_MAX_CURRENT         = 15'd4267;
	localparam logic [TRIES_W-1:0] RST_MAX_TRIES           = 4'd5;
	localparam logic [DUTY_W-1:0]  RST_INITIAL_DUTY        = 8'd75;

	localparam logic [RETRY_W-1:0] RETRY_MAX = 5'd31;

	typedef struct packed {
		logic [CODE_W-1:0] input_voltage_code;
		logic [CODE_W-1:0] battery_voltage_code;
		logic [CODE_W-1:0] battery_current_code;
		logic [CODE_W-1:0] load_current_code;
		logic [CODE_W-1:0] reference_code;
	} sample_t;

	typedef struct packed {
		logic [DUTY_W-1:0]           duty;
		logic [STATE_W-1:0]          charge_state;
		logic                        converter_enable;
		logic                        reverse_seen;
		logic signed [SUM_W-1:0]     battery_current_sum;
		logic signed [SUM_W-1:0]     load_current_sum;
		logic signed [OUT_PWR_W-1:0] battery_power;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0]         vin;
		logic [CODE_W-1:0]         vbat;
		logic signed [SUM_W-1:0]   bsum;
		logic signed [SUM_W-1:0]   lsum;
		logic signed [POWER_W-1:0] power;
	} work_t;

endpackage

`default_nettype wire

[hdl/mcc_channels.sv]
// ----------------------------------------------------------------------------
// mcc channels
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_in_if;
	logic             valid;
	logic             ready;
	mcc_pkg::sample_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mcc_out_if;
	logic             valid;
	logic             ready;
	mcc_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mcc_cfg_if;
	logic          valid;
	logic          ready;
	mcc_pkg::cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/mcc_front.sv]
// ----------------------------------------------------------------------------
// mcc_front
// Takes in ADC code sets, updates the two moving current sums and forms the
// battery power product for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_front #(
	parameter int FILTER_TAPS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mcc_in_if.sink              sample,
	output logic                push_valid,
	input  wire logic           push_ready,
	output mcc_pkg::work_t      push_data
);
	import mcc_pkg::*;

	logic signed [SAMPLE_W-1:0] bring_q [FILTER_TAPS];
	logic signed [SAMPLE_W-1:0] lring_q [FILTER_TAPS];
	logic signed [SUM_W-1:0]    bsum_q, lsum_q;
	logic signed [SAMPLE_W-1:0] bsample, lsample;
	logic signed [SUM_W-1:0]    bsum_d, lsum_d;
	logic                       accept;

	logic                       valid_s1;
	logic [CODE_W-1:0]          vin_s1, vbat_s1;
	logic signed [SUM_W-1:0]    bsum_s1, lsum_s1;
	logic signed [TOTAL_W-1:0]  total;

	assign sample.ready = !valid_s1 || push_ready;
	assign accept       = sample.valid && sample.ready;

	// current samples in half-code units
	assign bsample = $signed({1'b0, sample.data.battery_current_code, 1'b0})
		- $signed({2'b00, sample.data.reference_code});
	assign lsample = $signed({1'b0, sample.data.load_current_code, 1'b0})
		- $signed({2'b00, sample.data.reference_code});

	assign bsum_d = bsum_q - SUM_W'(bring_q[FILTER_TAPS-1]) + SUM_W'(bsample);
	assign lsum_d = lsum_q - SUM_W'(lring_q[FILTER_TAPS-1]) + SUM_W'(lsample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_TAPS; i++) begin
				bring_q[i] <= '0;
				lring_q[i] <= '0;
			end
			bsum_q <= '0;
			lsum_q <= '0;
		end else if (accept) begin
			bring_q[0] <= bsample;
			lring_q[0] <= lsample;
			for (int i = 1; i < FILTER_TAPS; i++) begin
				bring_q[i] <= bring_q[i-1];
				lring_q[i] <= lring_q[i-1];
			end
			bsum_q <= bsum_d;
			lsum_q <= lsum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vin_s1  <= sample.data.input_voltage_code;
			vbat_s1 <= sample.data.battery_voltage_code;
			bsum_s1 <= bsum_d;
			lsum_s1 <= lsum_d;
		end
	end

	assign total = TOTAL_W'(bsum_s1) + TOTAL_W'(lsum_s1);

	assign push_valid      = valid_s1;
	assign push_data.vin   = vin_s1;
	assign push_data.vbat  = vbat_s1;
	assign push_data.bsum  = bsum_s1;
	assign push_data.lsum  = lsum_s1;
	assign push_data.power = $signed({{(POWER_W-CODE_W){1'b0}}, vbat_s1}) * POWER_W'(total);

endmodule

`default_nettype wire

[hdl/mcc_queue.sv]
// ----------------------------------------------------------------------------
// mcc_queue
// Short queue of filtered requests between the front end and the charge
// state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire mcc_pkg::work_t  push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output mcc_pkg::work_t       pop_data
);
	import mcc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0]   COUNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

	work_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push, pop;

	assign push_ready = count_q != COUNT_FULL;
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[hdl/mcc_back.sv]
// ----------------------------------------------------------------------------
// mcc_back
// Configuration registers, charge state machine, perturb-and-observe duty
// stepping and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_back #(
	parameter int DUTY_TOP = 250
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	mcc_cfg_if.sink              cfg,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire mcc_pkg::work_t  pop_data,
	mcc_out_if.source            result
);
	import mcc_pkg::*;

	localparam logic [DUTY_W-1:0] DUTY_TOP_C  = DUTY_W'(DUTY_TOP);
	localparam logic [DUTY_W-1:0] DUTY_LAST_C = DUTY_W'(DUTY_TOP - 1);

	logic [CODE_W-1:0]  target_q, min_vbat_q;
	logic [TOL_W-1:0]   tolerance_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [TRIES_W-1:0] tries_q;

	logic [STATE_W-1:0]        mode_q, mode_d;
	logic [DUTY_W-1:0]         duty_q, duty_d;
	logic                      step_q, step_d;
	logic [RETRY_W-1:0]        retry_q, retry_d;
	logic                      rev_q, rev_d;
	logic                      conv_q, conv_d;
	logic signed [POWER_W-1:0] prev_q, prev_d;
	logic                      do_step;

	logic                      res_valid_q;
	result_t                   res_q;
	logic                      take, cfg_write;

	logic signed [TOTAL_W-1:0] bsum_x, limit_x;
	logic signed [CODE_W+1:0]  vbat_x, floor_x;
	logic [CODE_W-1:0]         vin, vbat;

	assign cfg.ready  = 1'b1;
	assign cfg_write  = cfg.valid;
	assign pop_ready  = !res_valid_q || result.ready;
	assign take       = pop_valid && pop_ready;

	assign vin     = pop_data.vin;
	assign vbat    = pop_data.vbat;
	assign bsum_x  = TOTAL_W'(pop_data.bsum);
	assign limit_x = $signed({2'b00, limit_q});
	assign vbat_x  = $signed({2'b00, vbat});
	assign floor_x = $signed({2'b00, target_q}) - $signed({5'b00000, tolerance_q});

	always_comb begin
		mode_d  = mode_q;
		duty_d  = duty_q;
		step_d  = step_q;
		retry_d = retry_q;
		rev_d   = rev_q;
		conv_d  = conv_q;
		prev_d  = prev_q;
		do_step = 1'b0;
		case (mode_q)
			MODE_INITIAL: begin
				if (vbat > min_vbat_q && vin > vbat && vbat < target_q) begin
					mode_d = MODE_TRACKING;
					rev_d  = 1'b0;
					conv_d = 1'b1;
				end
			end
			MODE_TRACKING: begin
				if (vbat > target_q) begin
					mode_d = MODE_STOPPED;
				end else if (bsum_x > limit_x) begin
					mode_d  = MODE_OVERCURRENT;
					retry_d = '0;
					step_d  = 1'b1;
				end else if (vbat > vin) begin
					rev_d  = 1'b1;
					conv_d = 1'b0;
					mode_d = MODE_INITIAL;
				end else if (prev_q > pop_data.power) begin
					step_d = ~step_q;
				end else if (duty_q == '0) begin
					duty_d = DUTY_W'(1);
				end else if (duty_q >= DUTY_TOP_C) begin
					duty_d = DUTY_LAST_C;
				end
				do_step = 1'b1;
			end
			MODE_OVERCURRENT: begin
				if (retry_q > {1'b0, tries_q}) begin
					mode_d = MODE_STOPPED;
				end else if (bsum_x < limit_x) begin
					mode_d = MODE_TRACKING;
				end else if (vbat > vin) begin
					rev_d  = 1'b1;
					conv_d = 1'b0;
					mode_d = MODE_INITIAL;
				end
				do_step = 1'b1;
				if (retry_q != RETRY_MAX) begin
					retry_d = retry_q + 1'b1;
				end
			end
			default: begin
				conv_d = 1'b0;
				if (vbat_x < floor_x) begin
					mode_d = MODE_INITIAL;
					rev_d  = 1'b0;
				end
			end
		endcase
		// duty step guard
		if (do_step && duty_d != '0 && duty_d < DUTY_TOP_C) begin
			duty_d = step_d ? duty_d - 1'b1 : duty_d + 1'b1;
			prev_d = pop_data.power;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= RST_TARGET_VOLTAGE;
			tolerance_q <= RST_VOLTAGE_TOLERANCE;
			min_vbat_q  <= RST_MIN_BATTERY_VOLTAGE;
			limit_q     <= RST_MAX_CURRENT;
			tries_q     <= RST_MAX_TRIES;
			mode_q      <= MODE_INITIAL;
			duty_q      <= RST_INITIAL_DUTY;
			step_q      <= 1'b0;
			retry_q     <= '0;
			rev_q       <= 1'b0;
			conv_q      <= 1'b0;
			prev_q      <= '1;
		end else begin
			if (take) begin
				mode_q  <= mode_d;
				duty_q  <= duty_d;
				step_q  <= step_d;
				retry_q <= retry_d;
				rev_q   <= rev_d;
				conv_q  <= conv_d;
				prev_q  <= prev_d;
			end
			if (cfg_write) begin
				case (cfg.data.index)
					CFG_TARGET_VOLTAGE:      target_q    <= cfg.data.value[CODE_W-1:0];
					CFG_VOLTAGE_TOLERANCE:   tolerance_q <= cfg.data.value[TOL_W-1:0];
					CFG_MIN_BATTERY_VOLTAGE: min_vbat_q  <= cfg.data.value[CODE_W-1:0];
					CFG_MAX_CURRENT:         limit_q     <= cfg.data.value[LIMIT_W-1:0];
					CFG_MAX_TRIES:           tries_q     <= cfg.data.value[TRIES_W-1:0];
					CFG_INITIAL_DUTY:        duty_q      <= cfg.data.value[DUTY_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.duty                <= duty_d;
			res_q.charge_state        <= mode_d;
			res_q.converter_enable    <= conv_d;
			res_q.reverse_seen        <= rev_d;
			res_q.battery_current_sum <= pop_data.bsum;
			res_q.load_current_sum    <= pop_data.lsum;
			res_q.battery_power       <= pop_data.power[OUT_PWR_W-1:0];
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

[hdl/mppt_charge_controller.sv]
// ----------------------------------------------------------------------------
// mppt_charge_controller
// Perturb-and-observe charge controller working on raw ADC code sets.
//
// Channels: sample takes one set of five ADC codes per request, result gives
// one status request per sample (duty, charge state, converter enable,
// reverse mark, both moving current sums and battery power). cfg writes one
// of six threshold registers by index; it is always ready and must only be
// used while no sample is in flight.
// Path: a sample passes the filter register, its power product goes into the
// queue, and the result register then gives the result.
// Throughput: one sample per cycle while the receiver does not stall; the
// charge state machine forms its next state combinationally on the queue head,
// and the power multiply sits between the filter register and the queue.
// Reset: sums, filter taps and state clear, duty loads the initial duty and
// the registers return to their defaults; no sweep is needed.
// Receiver stall: the result register holds, the two-entry queue and the
// filter register fill, then sample ready drops. Nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module mppt_charge_controller #(
	parameter int FILTER_TAPS = 8,
	parameter int DUTY_TOP    = 250
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mcc_in_if.sink    sample,
	mcc_out_if.source result,
	mcc_cfg_if.sink   cfg
);
	import mcc_pkg::*;

	logic  push_valid, push_ready, pop_valid, pop_ready;
	work_t push_data, pop_data;

	mcc_front #(
		.FILTER_TAPS (FILTER_TAPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mcc_back #(
		.DUTY_TOP (DUTY_TOP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

`default_nettype wire
